// ===== hw/rtl/atdmd_pkg.sv =====
// Shared types, constants and helper functions for the ARP table duplicate MAC detector.
// Depends on nothing; every other file of the block imports it.
package atdmd_pkg;

	localparam int MAC_W = 48;
	localparam int COL_W = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_SP = 8'h20;

	localparam logic [COL_W-1:0] MAC_COLUMN_RST = 3'd3;
	localparam logic SKIP_HEADER_RST = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAC_COLUMN = 1'b0,
		CFG_SKIP_HEADER = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [COL_W-1:0] mac_column;
		logic skip_header;
	} cfg_t;

	// Line parser state.
	typedef struct packed {
		logic header_done;
		logic [COL_W-1:0] token_index;
		logic in_token;
		logic [MAC_W-1:0] acc;
		logic captured;
	} parse_t;

	// Control flags of one beat travelling down the cell chain.
	typedef struct packed {
		logic valid;
		logic has_mac;
		logic is_end;
		logic dup;
		logic ovf;
	} beat_ctl_t;

	typedef struct packed {
		logic ok;
		logic [3:0] val;
	} hex_t;

	// Case-insensitive hex digit decode.
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// True while the open token is the MAC column of a line not yet captured.
	function automatic logic in_mac(input parse_t s, input logic [COL_W-1:0] col);
		return s.in_token && !s.captured && (s.token_index == col);
	endfunction

	// Close the open token, marking the line captured if it was the MAC token.
	function automatic parse_t close_token(input parse_t s, input logic [COL_W-1:0] col);
		parse_t r;
		r = s;
		if (s.in_token) begin
			if (in_mac(s, col)) begin
				r.captured = 1'b1;
			end
			r.acc = '0;
			r.in_token = 1'b0;
			r.token_index = s.token_index + COL_W'(1);
		end
		return r;
	endfunction

	// Start a fresh line after the open token has been closed.
	function automatic parse_t new_line(input parse_t s);
		parse_t r;
		r = s;
		r.token_index = '0;
		r.captured = 1'b0;
		r.acc = '0;
		return r;
	endfunction

endpackage

// ===== hw/rtl/atdmd_parser.sv =====
// Byte parser: header skip, tokenizing, MAC packing and entry counting.
// Depends on atdmd_pkg; feeds the first cell of the compare chain.
module atdmd_parser import atdmd_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic accept,
	input logic adv,
	input logic [7:0] text_byte,
	input logic table_end,
	output beat_ctl_t beat_ctl_s1,
	output logic [MAC_W-1:0] beat_mac_s1,
	output logic [CW-1:0] beat_slot_s1
);

	parse_t psr_q, psr_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic ovf_q, ovf_n;
	logic store;
	logic [MAC_W-1:0] smac;
	hex_t hv;
	beat_ctl_t ctl_n;

	// Next parser state and the store event for the accepted byte.
	always_comb begin
		psr_n = psr_q;
		store = 1'b0;
		smac = '0;
		hv = hex_digit(text_byte);
		if (cfg.skip_header && !psr_q.header_done) begin
			if (text_byte == CHAR_NL) begin
				psr_n.header_done = 1'b1;
			end
		end else if (text_byte == CHAR_NL || text_byte == CHAR_SP) begin
			if (in_mac(psr_n, cfg.mac_column)) begin
				store = 1'b1;
				smac = psr_n.acc;
			end
			psr_n = close_token(psr_n, cfg.mac_column);
			if (text_byte == CHAR_NL) begin
				psr_n = new_line(psr_n);
			end
		end else begin
			if (!psr_n.in_token) begin
				psr_n.in_token = 1'b1;
				psr_n.acc = '0;
			end
			if (hv.ok && in_mac(psr_n, cfg.mac_column)) begin
				psr_n.acc = {psr_n.acc[MAC_W-5:0], hv.val};
			end
		end

		// The last byte closes any open token as a newline would.
		if (table_end) begin
			if (in_mac(psr_n, cfg.mac_column)) begin
				store = 1'b1;
				smac = psr_n.acc;
			end
			psr_n = new_line(close_token(psr_n, cfg.mac_column));
		end

		// Slot assignment and overflow.
		cnt_n = cnt_q;
		ovf_n = ovf_q;
		if (store) begin
			if (cnt_q < CW'(TABLE_DEPTH)) begin
				cnt_n = cnt_q + CW'(1);
			end else begin
				ovf_n = 1'b1;
			end
		end

		ctl_n.valid = store || table_end;
		ctl_n.has_mac = store;
		ctl_n.is_end = table_end;
		ctl_n.dup = 1'b0;
		ctl_n.ovf = ovf_n;

		if (table_end) begin
			psr_n = '0;
			cnt_n = '0;
			ovf_n = 1'b0;
		end
	end

	// Parser state advances on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psr_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			psr_q <= psr_n;
			cnt_q <= cnt_n;
			ovf_q <= ovf_n;
		end
	end

	// Beat register in front of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_ctl_s1 <= '0;
		end else if (adv) begin
			beat_ctl_s1 <= accept ? ctl_n : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			beat_mac_s1 <= smac;
			beat_slot_s1 <= cnt_q;
		end
	end

endmodule

// ===== hw/rtl/atdmd_cell.sv =====
// One cell of the compare chain: holds one stored MAC and passes beats on.
// Depends on atdmd_pkg.
module atdmd_cell import atdmd_pkg::*; #(
	parameter int CW = 6,
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input beat_ctl_t in_ctl,
	input logic [MAC_W-1:0] in_mac,
	input logic [CW-1:0] in_slot,
	output beat_ctl_t out_ctl,
	output logic [MAC_W-1:0] out_mac,
	output logic [CW-1:0] out_slot
);

	logic [MAC_W-1:0] entry_q;
	logic hit, wr;
	beat_ctl_t pass_ctl;

	// Earlier entries are compared; the beat's own slot is written here.
	assign hit = in_ctl.valid && in_ctl.has_mac && (in_slot > CW'(IDX)) && (entry_q == in_mac);
	assign wr = in_ctl.valid && in_ctl.has_mac && (in_slot == CW'(IDX));

	always_ff @(posedge clk) begin
		if (adv && wr) begin
			entry_q <= in_mac;
		end
	end

	// Control flags of the beat with this cell's match folded in.
	always_comb begin
		pass_ctl = in_ctl;
		pass_ctl.dup = in_ctl.dup || hit;
	end

	// Beat moves on to the next cell, collecting the match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else if (adv) begin
			out_ctl <= pass_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_mac <= in_mac;
			out_slot <= in_slot;
		end
	end

endmodule

// ===== hw/rtl/arp_table_duplicate_mac_detector.sv =====
// Top level of the ARP table duplicate MAC detector: config, cell chain and result register.
// Depends on atdmd_pkg, atdmd_parser and atdmd_cell.
//
//  channel | signals                                      | direction
//  in      | in_valid, in_stall, text_byte, table_end     | text bytes in
//  out     | out_valid, out_stall, duplicate_found,        | one result beat
//          | entries_seen, table_overflow                  |   per table
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data     | register writes
//
// One byte is accepted per cycle while in_stall is low. A stored MAC walks a row of
// TABLE_DEPTH cells, one per cycle while the chain advances, and is compared with the entry
// of each cell it passes. Reset clears all control state; the stored entries need no
// clearing. The whole chain holds only while a result beat waits at the end of the chain
// behind a stalled, full output register.
module arp_table_duplicate_mac_detector import atdmd_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] text_byte,
	input logic table_end,
	output logic out_valid,
	input logic out_stall,
	output logic duplicate_found,
	output logic [5:0] entries_seen,
	output logic table_overflow,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	cfg_t cfg_q;
	beat_ctl_t chain_ctl [0:TABLE_DEPTH];
	logic [MAC_W-1:0] chain_mac [0:TABLE_DEPTH];
	logic [CW-1:0] chain_slot [0:TABLE_DEPTH];
	beat_ctl_t tail_ctl;
	logic [CW-1:0] tail_slot;
	logic adv, accept;
	logic dup_q;
	logic out_valid_q;
	logic [CW-1:0] end_cnt;
	logic [5:0] end_seen;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mac_column <= MAC_COLUMN_RST;
			cfg_q.skip_header <= SKIP_HEADER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MAC_COLUMN: cfg_q.mac_column <= cfg_data[COL_W-1:0];
				CFG_SKIP_HEADER: cfg_q.skip_header <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Global advance: hold only when a result beat cannot leave the chain.
	assign tail_ctl = chain_ctl[TABLE_DEPTH];
	assign tail_slot = chain_slot[TABLE_DEPTH];
	assign adv = !(tail_ctl.valid && tail_ctl.is_end && out_valid_q && out_stall);
	assign in_stall = !adv;
	assign accept = in_valid && adv;

	atdmd_parser #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.CW(CW)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.accept(accept),
		.adv(adv),
		.text_byte(text_byte),
		.table_end(table_end),
		.beat_ctl_s1(chain_ctl[0]),
		.beat_mac_s1(chain_mac[0]),
		.beat_slot_s1(chain_slot[0])
	);

	// Row of compare cells, one per table entry.
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		atdmd_cell #(
			.CW(CW),
			.IDX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.in_ctl(chain_ctl[k]),
			.in_mac(chain_mac[k]),
			.in_slot(chain_slot[k]),
			.out_ctl(chain_ctl[k+1]),
			.out_mac(chain_mac[k+1]),
			.out_slot(chain_slot[k+1])
		);
	end

	// Entry count at the end of the table, saturated to the field width.
	always_comb begin
		end_cnt = tail_slot;
		if (tail_ctl.has_mac && tail_slot < CW'(TABLE_DEPTH)) begin
			end_cnt = tail_slot + CW'(1);
		end
		if (32'(end_cnt) > 32'd63) begin
			end_seen = 6'd63;
		end else begin
			end_seen = 6'(end_cnt);
		end
	end

	// Sticky duplicate flag of the table now leaving the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q <= 1'b0;
		end else if (adv && tail_ctl.valid) begin
			dup_q <= tail_ctl.is_end ? 1'b0 : (dup_q || tail_ctl.dup);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && tail_ctl.valid && tail_ctl.is_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail_ctl.valid && tail_ctl.is_end) begin
			duplicate_found <= dup_q || tail_ctl.dup;
			entries_seen <= end_seen;
			table_overflow <= tail_ctl.ovf;
		end
	end

	assign out_valid = out_valid_q;

endmodule
